@@ rtl/ppd_pkg.sv @@
package ppd_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_PULSE_MIN      = 3'd0;
    localparam logic [2:0] REG_PULSE_MAX      = 3'd1;
    localparam logic [2:0] REG_SYNC_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_TIMER_TOP      = 3'd3;
    localparam logic [2:0] REG_SKIP_A         = 3'd4;
    localparam logic [2:0] REG_SKIP_B         = 3'd5;
    localparam logic [2:0] REG_SKIP_C         = 3'd6;

    localparam logic [15:0] PULSE_MIN_RST      = 16'd1000;
    localparam logic [15:0] PULSE_MAX_RST      = 16'd4200;
    localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd5500;
    localparam logic [15:0] TIMER_TOP_RST      = 16'd65535;

    typedef struct packed {
        logic [15:0] pulse_min;
        logic [15:0] pulse_max;
        logic [15:0] sync_threshold;
        logic [15:0] timer_top;
        logic [4:0]  skip_a;
        logic [4:0]  skip_b;
        logic [4:0]  skip_c;
    } ppd_cfg_t;

    typedef struct packed {
        logic        write_valid;
        logic [4:0]  write_channel;
        logic [15:0] pulse_width;
        logic        frame_end;
        logic [7:0]  channels_detected;
    } ppd_result_t;

endpackage

@@ rtl/ppd_cfg_regs.sv @@
module ppd_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output ppd_pkg::ppd_cfg_t cfg
);
    import ppd_pkg::*;

    ppd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_min      <= PULSE_MIN_RST;
            cfg_reg.pulse_max      <= PULSE_MAX_RST;
            cfg_reg.sync_threshold <= SYNC_THRESHOLD_RST;
            cfg_reg.timer_top      <= TIMER_TOP_RST;
            cfg_reg.skip_a         <= 5'd0;
            cfg_reg.skip_b         <= 5'd0;
            cfg_reg.skip_c         <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PULSE_MIN:      cfg_reg.pulse_min      <= cfg_data;
                REG_PULSE_MAX:      cfg_reg.pulse_max      <= cfg_data;
                REG_SYNC_THRESHOLD: cfg_reg.sync_threshold <= cfg_data;
                REG_TIMER_TOP:      cfg_reg.timer_top      <= cfg_data;
                REG_SKIP_A:         cfg_reg.skip_a         <= cfg_data[4:0];
                REG_SKIP_B:         cfg_reg.skip_b         <= cfg_data[4:0];
                REG_SKIP_C:         cfg_reg.skip_c         <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/ppd_core.sv @@
module ppd_core #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  logic [15:0]          capture_time,
    input  ppd_pkg::ppd_cfg_t    cfg,
    output ppd_pkg::ppd_result_t result
);
    import ppd_pkg::*;

    localparam logic [8:0] MaxCh = 9'(MAX_CHANNELS);

    logic [15:0] last_capture_reg, last_capture_next;
    logic [7:0]  channel_count_reg, channel_count_next;
    logic [7:0]  detected_count_reg, detected_count_next;

    logic [15:0] interval;
    logic [8:0]  ch;
    logic [7:0]  count_inc;
    logic        is_sync;
    logic        is_pulse;
    logic        is_long;
    logic        skip;

    always_comb
    begin
        // Wrap correction when the timer rolled over at its top.
        if (last_capture_reg > capture_time)
            interval = capture_time + (cfg.timer_top - last_capture_reg);
        else
            interval = capture_time - last_capture_reg;

        ch        = {1'b0, channel_count_reg} + 9'd1;
        count_inc = (channel_count_reg == 8'hFF) ? channel_count_reg : ch[7:0];
        is_sync   = interval > cfg.sync_threshold;
        is_pulse  = ({1'b0, channel_count_reg} < MaxCh) &&
                    (interval > cfg.pulse_min) && (interval < cfg.pulse_max);
        is_long   = interval > cfg.pulse_min;
        skip      = (ch == {4'd0, cfg.skip_a}) || (ch == {4'd0, cfg.skip_b}) ||
                    (ch == {4'd0, cfg.skip_c});

        last_capture_next   = capture_time;
        channel_count_next  = channel_count_reg;
        detected_count_next = detected_count_reg;

        result.write_valid   = 1'b0;
        result.write_channel = 5'd0;
        result.pulse_width   = interval;
        result.frame_end     = 1'b0;

        if (is_sync)
        begin
            detected_count_next = channel_count_reg;
            channel_count_next  = 8'd0;
            result.frame_end    = 1'b1;
        end
        else if (is_pulse)
        begin
            result.write_valid   = !skip;
            result.write_channel = skip ? 5'd0 : ch[4:0];
            channel_count_next   = count_inc;
        end
        else if (is_long)
        begin
            channel_count_next = count_inc;
        end

        result.channels_detected = detected_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_capture_reg   <= 16'd0;
            channel_count_reg  <= 8'd0;
            detected_count_reg <= 8'd0;
        end
        else if (in_accept)
        begin
            last_capture_reg   <= last_capture_next;
            channel_count_reg  <= channel_count_next;
            detected_count_reg <= detected_count_next;
        end
    end

    // A sync gap always clears the running channel count.
    a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && is_sync |=> channel_count_reg == 8'd0)
        else $error("channel count not cleared after sync gap");

    // Outside a sync gap the count never goes down.
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !is_sync |=> channel_count_reg >= $past(channel_count_reg))
        else $error("channel count decreased without sync gap");

    // A channel write and a frame end never come from the same interval.
    a_write_not_sync: assert property (@(posedge clk) disable iff (!rst_n)
        result.write_valid |-> !result.frame_end)
        else $error("channel write flagged on a sync gap");

endmodule

@@ rtl/ppm_pulse_decoder_top.sv @@
// PPM pulse-train decoder.
// The slave stream (s_tvalid, s_tready, s_tdata) carries one captured edge
// timestamp per word. For each word the block measures the interval to the
// previous timestamp, with wrap correction at the configured timer top, and
// classifies it as a sync gap, a channel pulse or an out-of-range interval.
// Exactly one result word leaves on the master stream for each input word.
// m_tlast marks a sync gap (frame end) and m_tuser flags a channel write.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the pulse
// bounds, sync threshold, timer top and the three skip channels; it should
// only be written while no word is in flight.
// The result word is registered and shows in the output register in the
// cycle after its input word is accepted. Throughput is one word per cycle
// unless the receiver stalls, set by the single subtract-and-compare pass.
// When the receiver stalls, the output register holds its word and s_tready
// falls; input is taken again in the same cycle the held word is taken.
// Reset clears the previous timestamp, both channel counters and the output
// valid flag, and loads the registers with their default values.
module ppm_pulse_decoder_top #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Fields from bit 0: capture_time[15:0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // Fields from bit 0: write_channel[4:0], pulse_width[20:5],
    // channels_detected[28:21], zero fill[31:29].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // frame_end: set when the interval was a sync gap.
    output logic        m_tlast,
    // Fields from bit 0: write_valid[0].
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ppd_pkg::*;

    ppd_cfg_t    cfg;
    ppd_result_t result;
    ppd_result_t out_reg;
    logic        out_valid_reg;
    logic        in_accept;

    // The output register frees up whenever its word is taken this cycle.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    ppd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppd_core #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .capture_time (s_tdata),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    // Payload needs no reset; it is loaded on every accepted word.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.channels_detected, out_reg.pulse_width,
                       out_reg.write_channel};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = out_reg.write_valid;

endmodule
